@@ sv/range_lookaside_cache_top_macros.svh @@
// assertion macros for the range lookaside cache
// used by modules that check their own control logic; needs clk and rst_n in scope
`ifndef RANGE_LOOKASIDE_CACHE_TOP_MACROS_SVH
`define RANGE_LOOKASIDE_CACHE_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define RLC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlc assertion failed");
// next-cycle implication
`define RLC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlc assertion failed");
`else
`define RLC_ASSERT_IMP(lbl, ante, cons)
`define RLC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/rlc_pkg.sv @@
// shared types and constants for the range lookaside cache
// no dependencies
package rlc_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = $clog2(SLOTS);

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef struct packed {
        logic [31:0] pool;
        logic [31:0] base;
        logic [31:0] limit;
        logic [31:0] chunk;
        logic [15:0] index;
    } slot_entry_t;

    // write request from the sequencer into the slot store
    typedef struct packed {
        logic        en;
        slot_idx_t   slot;
        slot_entry_t entry;
    } store_wr_t;

    // key presented to the compare unit
    typedef struct packed {
        logic [31:0] pool;
        logic [31:0] addr;
    } look_key_t;

endpackage

@@ sv/rlc_if.sv @@
// request and response channel interfaces for the range lookaside cache
// no dependencies
interface rlc_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] pool_tag;
    logic [31:0] block_addr;
    logic [31:0] region_base;
    logic [31:0] region_size;
    logic [31:0] chunk_ref;
    logic [15:0] chunk_index;

    modport source (output valid, cmd, pool_tag, block_addr, region_base, region_size,
                    chunk_ref, chunk_index, input ready);
    modport sink (input valid, cmd, pool_tag, block_addr, region_base, region_size,
                  chunk_ref, chunk_index, output ready);
endinterface

interface rlc_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] found_chunk;
    logic [15:0] found_index;

    modport source (output valid, hit, found_chunk, found_index, input ready);
    modport sink (input valid, hit, found_chunk, found_index, output ready);
endinterface

@@ sv/rlc_slot_store.sv @@
// slot storage of the range lookaside cache: one write port, one read port
// depends on rlc_pkg
module rlc_slot_store
    import rlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  store_wr_t   wr,
    input  slot_idx_t   rd_slot,
    output slot_entry_t rd_entry,
    output logic        rd_valid
);

    slot_entry_t            slot_mem [SLOTS];
    logic [SLOTS-1:0]       written_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr.en)
        begin
            written_reg[wr.slot] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            slot_mem[wr.slot] <= wr.entry;
        end
    end

    // a slot never written since reset reads as empty
    assign rd_entry = written_reg[rd_slot] ? slot_mem[rd_slot] : '0;
    assign rd_valid = (rd_entry.chunk != 32'd0);

endmodule

@@ sv/rlc_match_unit.sv @@
// shared compare unit: checks one slot against the lookup key
// depends on rlc_pkg
module rlc_match_unit
    import rlc_pkg::*;
(
    input  slot_entry_t entry,
    input  logic        entry_valid,
    input  look_key_t   key,
    output logic        match
);

    logic pool_eq;
    logic above_base;
    logic below_limit;

    assign pool_eq     = (entry.pool == key.pool);
    assign above_base  = (key.addr >= entry.base);
    assign below_limit = (key.addr < entry.limit);
    assign match       = entry_valid && pool_eq && above_base && below_limit;

endmodule

@@ sv/rlc_seq.sv @@
// sequencer: takes requests, walks the slots one per cycle, holds the result register
// depends on rlc_pkg, rlc_if and the assertion macro header
`include "range_lookaside_cache_top_macros.svh"

module rlc_seq
    import rlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rlc_req_if.sink     req,
    rlc_rsp_if.source   rsp,
    output store_wr_t   wr,
    output slot_idx_t   rd_slot,
    output look_key_t   key,
    input  slot_entry_t rd_entry,
    input  logic        slot_match
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_INSERT = 3'b100
    } seq_state_t;

    localparam slot_idx_t LAST_SLOT = slot_idx_t'(SLOTS - 1);

    seq_state_t  state_reg, state_next;
    slot_idx_t   cur_reg, cur_next;
    slot_idx_t   cnt_reg, cnt_next;
    slot_idx_t   last_hit_reg, last_hit_next;
    slot_idx_t   ins_ptr_reg, ins_ptr_next;
    logic        out_valid_reg, out_valid_next;

    logic        cmd_reg, cmd_next;
    logic [31:0] pool_reg, pool_next;
    logic [31:0] addr_reg, addr_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] chunk_reg, chunk_next;
    logic [15:0] index_reg, index_next;

    logic        res_hit_reg, res_hit_next;
    logic [31:0] res_chunk_reg, res_chunk_next;
    logic [15:0] res_index_reg, res_index_next;

    logic        out_free;

    function automatic slot_idx_t wrap_inc(input slot_idx_t s);
        return (s == LAST_SLOT) ? '0 : s + slot_idx_t'(1);
    endfunction

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = res_hit_reg;
    assign rsp.found_chunk = res_chunk_reg;
    assign rsp.found_index = res_index_reg;

    assign rd_slot  = cur_reg;
    assign key.pool = pool_reg;
    assign key.addr = addr_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        last_hit_next  = last_hit_reg;
        ins_ptr_next   = ins_ptr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        cmd_next       = cmd_reg;
        pool_next      = pool_reg;
        addr_next      = addr_reg;
        base_next      = base_reg;
        size_next      = size_reg;
        chunk_next     = chunk_reg;
        index_next     = index_reg;
        res_hit_next   = res_hit_reg;
        res_chunk_next = res_chunk_reg;
        res_index_next = res_index_reg;

        wr.en          = 1'b0;
        wr.slot        = ins_ptr_reg;
        wr.entry.pool  = pool_reg;
        wr.entry.base  = base_reg;
        wr.entry.limit = base_reg + size_reg;
        wr.entry.chunk = chunk_reg;
        wr.entry.index = index_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.cmd;
                    pool_next  = req.pool_tag;
                    addr_next  = req.block_addr;
                    base_next  = req.region_base;
                    size_next  = req.region_size;
                    chunk_next = req.chunk_ref;
                    index_next = req.chunk_index;
                    cur_next   = last_hit_reg;
                    cnt_next   = '0;
                    state_next = req.cmd ? ST_INSERT : ST_LOOKUP;
                end
            end
            ST_INSERT:
            begin
                if (out_free)
                begin
                    wr.en          = 1'b1;
                    res_hit_next   = 1'b0;
                    res_chunk_next = '0;
                    res_index_next = '0;
                    out_valid_next = 1'b1;
                    last_hit_next  = ins_ptr_reg;
                    ins_ptr_next   = wrap_inc(ins_ptr_reg);
                    state_next     = ST_IDLE;
                end
            end
            ST_LOOKUP:
            begin
                if (slot_match)
                begin
                    if (out_free)
                    begin
                        res_hit_next   = 1'b1;
                        res_chunk_next = rd_entry.chunk;
                        res_index_next = rd_entry.index;
                        out_valid_next = 1'b1;
                        last_hit_next  = cur_reg;
                        state_next     = ST_IDLE;
                    end
                end
                else if (cnt_reg == LAST_SLOT)
                begin
                    // every slot checked, report a miss
                    if (out_free)
                    begin
                        res_hit_next   = 1'b0;
                        res_chunk_next = '0;
                        res_index_next = '0;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cur_next = wrap_inc(cur_reg);
                    cnt_next = cnt_reg + slot_idx_t'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            cnt_reg       <= '0;
            last_hit_reg  <= '0;
            ins_ptr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            cnt_reg       <= cnt_next;
            last_hit_reg  <= last_hit_next;
            ins_ptr_reg   <= ins_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pool_reg      <= pool_next;
        addr_reg      <= addr_next;
        base_reg      <= base_next;
        size_reg      <= size_next;
        chunk_reg     <= chunk_next;
        index_reg     <= index_next;
        res_hit_reg   <= res_hit_next;
        res_chunk_reg <= res_chunk_next;
        res_index_reg <= res_index_next;
    end

    // the latched command must agree with the branch taken
    `RLC_ASSERT_IMP(a_cmd_state, state_reg == ST_INSERT, cmd_reg)
    // an insert leaves its slot as the last hit
    `RLC_ASSERT_NEXT(a_insert_last_hit, state_reg == ST_INSERT && out_free,
                     last_hit_reg == $past(ins_ptr_reg))
    // a new result only comes out of a working state
    `RLC_ASSERT_IMP(a_result_source, $rose(out_valid_reg), $past(state_reg) != ST_IDLE)
    // a hit always names a valid slot
    `RLC_ASSERT_IMP(a_hit_nonzero, out_valid_reg && res_hit_reg, res_chunk_reg != 32'd0)
    // a miss or insert result carries zero fields
    `RLC_ASSERT_IMP(a_miss_zero, out_valid_reg && !res_hit_reg,
                    res_chunk_reg == 32'd0 && res_index_reg == 16'd0)

endmodule

@@ sv/range_lookaside_cache_top.sv @@
// range lookaside cache: a fully associative cache of address ranges
// lookup or insert requests on req, one result beat per request on rsp
// one request at a time; lookup compares one slot per cycle, rotating from the last hit
// the result register loads at the edge that ends the work: for an insert once the
// output register is free, for a lookup at a matching slot or after the last slot
// req.ready is high only while the sequencer is idle, so a new request is not
// accepted until the previous one has finished its work; the single compare
// unit walking the slots sets this pace
// the next request may be accepted while the previous result still waits in the
// output register
// a stalled rsp holds its beat; a finished request waits until the register frees
// reset empties all slots (valid bits cleared) and sets all slot pointers to zero
// depends on rlc_pkg, rlc_if, rlc_slot_store, rlc_match_unit, rlc_seq
module range_lookaside_cache_top
    import rlc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rlc_req_if.sink   req,
    rlc_rsp_if.source rsp
);

    store_wr_t   wr;
    slot_idx_t   rd_slot;
    slot_entry_t rd_entry;
    logic        rd_valid;
    look_key_t   key;
    logic        slot_match;

    rlc_slot_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd_slot  (rd_slot),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid)
    );

    rlc_match_unit u_match (
        .entry       (rd_entry),
        .entry_valid (rd_valid),
        .key         (key),
        .match       (slot_match)
    );

    rlc_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .wr         (wr),
        .rd_slot    (rd_slot),
        .key        (key),
        .rd_entry   (rd_entry),
        .slot_match (slot_match)
    );

endmodule
